>>> sv/npcm_pkg.sv
// Shared types, constants and helper functions for the nearest palette color match block.
package npcm_pkg;

  // Palette size and the number of entries that an 8-bit index can address.
  localparam int PALETTE_DEPTH = 256;
  localparam int INDEX_SPAN    = 256;
  localparam int NUM_CELLS     = (PALETTE_DEPTH < INDEX_SPAN) ? PALETTE_DEPTH : INDEX_SPAN;

  // Field widths.
  localparam int IDX_W   = 8;
  localparam int COMP_W  = 8;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int DIST_W  = 18;
  localparam int COUNT_W = 9;

  // Item kinds carried on the input tuser bit.
  localparam logic FUNC_WRITE    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  // One transaction as it moves along the row of cells, with the running best.
  typedef struct packed {
    logic              valid;
    logic              func;
    logic [IDX_W-1:0]  entry_index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              any;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;
  } token_t;

  // Square of the absolute difference of two color components.
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                              input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

>>> sv/npcm_cell.sv
// One palette cell: holds a single entry, squares the component differences, then updates the running best.
module npcm_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  logic [npcm_pkg::IDX_W-1:0]     cell_id,
  input  logic [npcm_pkg::COUNT_W-1:0]   entries_in_use,
  input  npcm_pkg::token_t               tok_in,
  output npcm_pkg::token_t               tok_out
);
  import npcm_pkg::*;

  logic [3*COMP_W-1:0] entry_r;
  token_t              tok1_r;
  token_t              tok2_r;
  logic [SQ_W-1:0]     sq_red_r;
  logic [SQ_W-1:0]     sq_green_r;
  logic [SQ_W-1:0]     sq_blue_r;
  logic [DIST_W-1:0]   sum_sq;
  logic                active;
  logic                take;
  token_t              tok2_nxt;

  // Entry load: a write transaction addressed to this cell replaces the entry as it passes.
  always_ff @(posedge clk) begin
    if (advance && tok_in.valid && (tok_in.func == FUNC_WRITE) &&
        (tok_in.entry_index == cell_id)) begin
      entry_r <= {tok_in.red, tok_in.green, tok_in.blue};
    end
  end

  // First stage: register the transaction and the three squared differences.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r.valid <= 1'b0;
    end else if (advance) begin
      tok1_r     <= tok_in;
      sq_red_r   <= sq_diff(entry_r[3*COMP_W-1:2*COMP_W], tok_in.red);
      sq_green_r <= sq_diff(entry_r[2*COMP_W-1:COMP_W], tok_in.green);
      sq_blue_r  <= sq_diff(entry_r[COMP_W-1:0], tok_in.blue);
    end
  end

  // Second stage: sum the squares and keep the better of this entry and the running best.
  always_comb begin
    active   = {1'b0, cell_id} < entries_in_use;
    sum_sq   = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);
    take     = tok1_r.valid && (tok1_r.func == FUNC_CLASSIFY) && active &&
               (!tok1_r.any || (sum_sq < tok1_r.best_dist));
    tok2_nxt = tok1_r;
    if (take) begin
      tok2_nxt.any       = 1'b1;
      tok2_nxt.best_idx  = cell_id;
      tok2_nxt.best_dist = sum_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok2_r.valid <= 1'b0;
    end else if (advance) begin
      tok2_r <= tok2_nxt;
    end
  end

  assign tok_out = tok2_r;

endmodule

>>> sv/nearest_palette_color_match_top.sv
// Top level of the nearest palette color match block: a row of palette cells and the result register.
//
//  Channel | Direction | Handshake             | Payload
//  in_     | input     | in_tvalid / in_tready | tuser: func; tdata: index, red, green, blue
//  out_    | output    | out_tvalid/out_tready | tdata: index, distance, exact, found
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_data: entries_in_use
//
// One transaction enters per cycle while the row is not stalled. Each of the NUM_CELLS cells
// has two register stages and the result register adds one, which drives out_tvalid.
// Write transactions travel the same row and load their cell in order with pixels.
// A held result that is not taken stalls the whole row and the input together.
// Reset clears the valid bits and entries_in_use; palette entries hold no reset value.
module nearest_palette_color_match_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input transactions.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_tuser,   // [0] func
  input  logic [31:0]                    in_tdata,   // [7:0] entry_index, [15:8] red,
                                                     // [23:16] green, [31:24] blue
  // Result transactions.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [7:0] match_index,
                                                     // [25:8] match_distance,
                                                     // [26] exact_match, [27] found,
                                                     // [31:28] zero
  // Configuration write.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [npcm_pkg::COUNT_W-1:0]   cfg_data
);
  import npcm_pkg::*;

  logic [COUNT_W-1:0] entries_in_use_r;
  logic               advance;
  token_t             head_tok;
  token_t             chain [NUM_CELLS+1];
  token_t             last_tok;
  logic               out_valid_r;
  logic [IDX_W-1:0]   match_index_r;
  logic [DIST_W-1:0]  match_distance_r;
  logic               exact_match_r;
  logic               found_r;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= '0;
    end else if (cfg_valid) begin
      entries_in_use_r <= cfg_data;
    end
  end

  // The row moves whenever the result register is free or being emptied.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  // Token entering the first cell.
  always_comb begin
    head_tok             = '0;
    head_tok.valid       = in_tvalid;
    head_tok.func        = in_tuser;
    head_tok.entry_index = in_tdata[7:0];
    head_tok.red         = in_tdata[15:8];
    head_tok.green       = in_tdata[23:16];
    head_tok.blue        = in_tdata[31:24];
  end

  assign chain[0] = head_tok;

  // Row of palette cells.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    npcm_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .advance        (advance),
      .cell_id        (IDX_W'(k)),
      .entries_in_use (entries_in_use_r),
      .tok_in         (chain[k]),
      .tok_out        (chain[k+1])
    );
  end

  assign last_tok = chain[NUM_CELLS];

  // Result register: only classify transactions produce a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last_tok.valid && (last_tok.func == FUNC_CLASSIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      match_index_r    <= (last_tok.best_idx == IDX_W'(1)) ? '0 : last_tok.best_idx;
      match_distance_r <= last_tok.best_dist;
      exact_match_r    <= last_tok.any && (last_tok.best_dist == '0);
      found_r          <= last_tok.any;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, found_r, exact_match_r, match_distance_r, match_index_r};

endmodule

>>> dv/nearest_palette_color_match_checker.sv
// Checker for the nearest palette color match block: predicts each match and compares results.
module nearest_palette_color_match_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic                         in_tuser,     // [0] func
  input  logic [31:0]                  in_tdata,     // [7:0] entry_index, [15:8] red,
                                                     // [23:16] green, [31:24] blue
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [31:0]                  out_tdata,    // [7:0] match_index, [25:8] match_distance,
                                                     // [26] exact_match, [27] found
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [npcm_pkg::COUNT_W-1:0] cfg_data,
  output int                           errors,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import npcm_pkg::*;

  // Result fields, declared from the top bit down so that the struct maps onto tdata.
  typedef struct packed {
    logic              found;
    logic              exact;
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  index;
  } match_t;

  // Our own copy of the palette, held as {red, green, blue}, and of the entry count.
  logic [3*COMP_W-1:0] palette_copy [PALETTE_DEPTH];
  logic [COUNT_W-1:0]  entries_searched;
  match_t              pending_matches [$];
  int                  fail_count = 0;
  int                  match_backlog = 0;

  assign errors      = fail_count;
  assign outstanding = match_backlog;

  // Search the entries in use for the least squared distance; the lowest index wins a tie.
  function automatic match_t nearest_color(input logic [COMP_W-1:0] red,
                                           input logic [COMP_W-1:0] green,
                                           input logic [COMP_W-1:0] blue);
    match_t              m;
    int                  limit;
    int                  dr;
    int                  dg;
    int                  db;
    int                  sum_sq;
    int                  best_dist;
    int                  best_idx;
    bit                  any;
    logic [3*COMP_W-1:0] e;
    limit = int'(entries_searched);
    if (limit > NUM_CELLS) limit = NUM_CELLS;
    best_dist = 0;
    best_idx  = 0;
    any       = 1'b0;
    for (int i = 0; i < limit; i++) begin
      e      = palette_copy[i];
      dr     = int'(e[23:16]) - int'(red);
      dg     = int'(e[15:8]) - int'(green);
      db     = int'(e[7:0]) - int'(blue);
      sum_sq = dr * dr + dg * dg + db * db;
      if (!any || sum_sq < best_dist) begin
        best_dist = sum_sq;
        best_idx  = i;
        any       = 1'b1;
      end
    end
    // Index one is always reported as zero.
    if (best_idx == 1) best_idx = 0;
    m.index    = IDX_W'(best_idx);
    m.distance = DIST_W'(best_dist);
    m.exact    = any && (best_dist == 0);
    m.found    = any;
    return m;
  endfunction

  // Watch all three channels at the rising edge.
  always @(posedge clk) begin
    match_t got;
    match_t want;
    if (!rst_n) begin
      entries_searched = '0;
      pending_matches.delete();
    end else begin
      // Result transaction: compare with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got = match_t'(out_tdata[27:0]);
        if (pending_matches.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index %0d distance %0d",
                   $time, got.index, got.distance);
          $display("  exact %0b found %0b", got.exact, got.found);
          fail_count++;
        end else begin
          want = pending_matches.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected index %0d distance %0d exact %0b found %0b",
                     $time, want.index, want.distance, want.exact, want.found);
            $display("  actual index %0d distance %0d exact %0b found %0b",
                     got.index, got.distance, got.exact, got.found);
            fail_count++;
          end
        end
      end
      // Input transaction: a write updates our palette, a classify makes a prediction.
      if (in_tvalid && in_tready) begin
        if (in_tuser == FUNC_CLASSIFY) begin
          pending_matches.push_back(nearest_color(in_tdata[15:8], in_tdata[23:16],
                                                  in_tdata[31:24]));
        end else if (int'(in_tdata[7:0]) < PALETTE_DEPTH) begin
          palette_copy[in_tdata[7:0]] = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
        end
      end
      // Configuration transaction.
      if (cfg_valid && cfg_ready) begin
        entries_searched = cfg_data;
      end
    end
    match_backlog = pending_matches.size();
  end

endmodule

>>> dv/nearest_palette_color_match_top_tb.sv
// Testbench top for the nearest palette color match block: stimulus, flow control and verdict.
module nearest_palette_color_match_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import npcm_pkg::*;

  // Cycles to let the row of cells empty out before touching the configuration.
  localparam int DRAIN_CYCLES = 2 * NUM_CELLS + 64;
  localparam int PHASE_ITEMS  = 130;
  localparam int NUM_PHASES   = 10;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic               in_tuser;
  logic [31:0]        in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [31:0]        out_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data;
  int                 errors;
  int                 outstanding;

  // Stimulus-side record of which entries hold a color, so no unwritten entry is searched.
  bit                  written [PALETTE_DEPTH];
  logic [3*COMP_W-1:0] shadow [PALETTE_DEPTH];
  bit                  steady;

  nearest_palette_color_match_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  nearest_palette_color_match_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Color source: random, copies of stored entries, corner values, or near neighbors.
  function automatic logic [3*COMP_W-1:0] rand_color();
    logic [3*COMP_W-1:0] c;
    int                  k;
    k = $urandom_range(0, PALETTE_DEPTH - 1);
    case ($urandom_range(0, 3))
      0: c = 24'($urandom());
      1: c = written[k] ? shadow[k] : 24'($urandom());
      2: begin
        c[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        c[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        c[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        c = written[k] ? shadow[k] : 24'h000000;
        c = c ^ {5'b0, 3'($urandom()), 5'b0, 3'($urandom()), 5'b0, 3'($urandom())};
      end
    endcase
    return c;
  endfunction

  // Number of consecutive entries from index zero that hold a color.
  function automatic int filled_prefix();
    int n;
    n = 0;
    while (n < PALETTE_DEPTH && written[n]) n++;
    return n;
  endfunction

  // Offer one input transaction after a random gap (none in steady mode) and wait for it to be taken.
  task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                           input logic [3*COMP_W-1:0] rgb);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = {rgb[7:0], rgb[15:8], rgb[23:16], idx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [3*COMP_W-1:0] rgb);
    send_item(FUNC_WRITE, idx, rgb);
    written[idx] = 1'b1;
    shadow[idx]  = rgb;
  endtask

  task automatic classify(input logic [3*COMP_W-1:0] rgb);
    send_item(FUNC_CLASSIFY, IDX_W'($urandom()), rgb);
  endtask

  // Change entries_in_use only once the row has emptied.
  task automatic set_entries_in_use(input logic [COUNT_W-1:0] value);
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: random stalls before each result transaction, none in steady mode.
  initial begin
    int wait_cycles;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      wait_cycles = steady ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        out_tready = 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Main stimulus.
  initial begin
    int                 cfg_plan [NUM_PHASES];
    logic [COUNT_W-1:0] count;
    int                 need;
    int                 fill;
    cfg_plan  = '{2, 255, 256, 511, 0, 257, 1, -1, 384, -1};
    in_tvalid = 1'b0;
    in_tuser  = FUNC_WRITE;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    steady    = 1'b0;
    rst_n     = 1'b0;
    for (int i = 0; i < PALETTE_DEPTH; i++) written[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty palette right after reset.
    classify(24'h000000);
    classify(24'hFFFFFF);

    // Black, two equal whites for the tie and index-one rule, one mid color, the top index.
    write_entry(8'd0, 24'h000000);
    write_entry(8'd1, 24'hFFFFFF);
    write_entry(8'd2, 24'hFFFFFF);
    write_entry(8'd3, 24'h804020);
    write_entry(8'd255, 24'hFF00FF);

    set_entries_in_use(9'd4);
    classify(24'hFFFFFF);
    classify(24'hFAFAFA);
    classify(24'h804020);
    classify(24'h000000);
    classify(24'hFF0000);
    classify(24'h7F7F7F);
    classify(24'h808080);

    // Only black searched: white gives the largest distance.
    set_entries_in_use(9'd1);
    classify(24'hFFFFFF);
    classify(24'h123456);

    // Random phases; every classify only searches entries already written.
    for (int p = 0; p < NUM_PHASES; p++) begin
      count = (cfg_plan[p] < 0) ? COUNT_W'($urandom_range(0, 511)) : COUNT_W'(cfg_plan[p]);
      set_entries_in_use(count);
      steady = (p % 4 == 2);
      need   = (int'(count) > NUM_CELLS) ? NUM_CELLS : int'(count);
      repeat (PHASE_ITEMS) begin
        fill = filled_prefix();
        if (fill < need) begin
          write_entry(IDX_W'(fill), rand_color());
        end else if ($urandom_range(0, 3) == 0) begin
          write_entry(IDX_W'($urandom()), rand_color());
        end else begin
          classify(rand_color());
        end
      end
    end

    // Drain and let any stray result show up.
    in_tvalid = 1'b0;
    steady    = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
sv/npcm_pkg.sv
sv/npcm_cell.sv
sv/nearest_palette_color_match_top.sv
dv/nearest_palette_color_match_checker.sv
dv/nearest_palette_color_match_top_tb.sv
